[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the onset detector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cod_pkg.sv]
// ----------------------------------------------------------------------------
// cod_pkg
// Types and constants shared by the compound onset detector modules.
// ----------------------------------------------------------------------------
package cod_pkg;

  localparam int SCORE_W  = 17;
  localparam int ENERGY_W = 32;
  localparam int CHANGE_W = 33;
  localparam int PEAK_W   = 34;
  localparam int LEVEL_W  = 2;
  localparam int MODE_W   = 2;
  localparam int RANK_W   = 5;
  localparam int RUN_W    = 4;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 17;
  localparam int S_DATA_W   = 56;
  localparam int M_DATA_W   = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_MODE      = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_E_RANK    = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_C_RANK    = 4'd3;

  // Detector modes; any other code runs as compound mode.
  localparam logic [MODE_W-1:0] MODE_PERC     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMPOUND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SOFT     = 2'd2;

  // Onset levels.
  localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_SOFT = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_HARD = 2'd2;

  localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 17'd22938;
  localparam logic [RANK_W-1:0]  E_RANK_RESET    = 5'd16;
  localparam logic [RANK_W-1:0]  C_RANK_RESET    = 5'd17;
  localparam logic [RUN_W-1:0]   RUN_MAX         = 4'd15;
  localparam logic [RUN_W-1:0]   RUN_MIN_SOFT    = 4'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [SCORE_W-1:0] threshold;
    logic [RANK_W-1:0]  energy_rank;
    logic [RANK_W-1:0]  change_rank;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic write_win;
    logic scan;
    logic decide;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic mode_zero;
    logic scan_last;
  } stat_t;

endpackage

[rtl/cod_regs.sv]
// ----------------------------------------------------------------------------
// cod_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module cod_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cod_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cod_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output cod_pkg::cfg_t                  cfg
);
  import cod_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= MODE_COMPOUND;
      cfg.threshold   <= THRESHOLD_RESET;
      cfg.energy_rank <= E_RANK_RESET;
      cfg.change_rank <= C_RANK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:      cfg.mode        <= cfg_wdata[MODE_W-1:0];
        REG_THRESHOLD: cfg.threshold   <= cfg_wdata[SCORE_W-1:0];
        REG_E_RANK:    cfg.energy_rank <= cfg_wdata[RANK_W-1:0];
        REG_C_RANK:    cfg.change_rank <= cfg_wdata[RANK_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/cod_ctrl.sv]
// ----------------------------------------------------------------------------
// cod_ctrl
// Sequencer: takes a request, steps the datapath through window update, rank
// scan and decision (skipped in percussive mode), holds the result till taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cod_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  cod_pkg::stat_t stat,
  output cod_pkg::cmd_t  cmd
);
  import cod_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  state_t state;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load_in   = s_tvalid && s_tready;
    cmd.write_win = (state == ST_WRITE);
    cmd.scan      = (state == ST_SCAN);
    cmd.decide    = (state == ST_DECIDE);
    cmd.load_out  = (state == ST_EMIT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.load_in) begin
            state <= stat.mode_zero ? ST_EMIT : ST_WRITE;
          end
        end
        ST_WRITE:  state <= ST_SCAN;
        ST_SCAN: begin
          if (stat.scan_last) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: state <= ST_EMIT;
        ST_EMIT: begin
          if (cmd.load_out) begin
            state <= ST_IDLE;
          end
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_one_item_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready,
               "a second request was taken while one is in work")
  `ASSERT_ALWAYS(a_emit_into_free_slot, clk, rst, !cmd.load_out || !m_tvalid || m_tready,
                 "result loaded over one that was not taken")

endmodule

[rtl/cod_dp.sv]
// ----------------------------------------------------------------------------
// cod_dp
// Datapath: input capture, the two percentile windows with a one-candidate-
// per-cycle rank scan, the onset decision and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cod_dp #(
  parameter int WINDOW_LEN = 19
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cod_pkg::cmd_t                 cmd,
  input  cod_pkg::cfg_t                 cfg,
  input  logic [cod_pkg::SCORE_W-1:0]   percussive_score,
  input  logic [cod_pkg::ENERGY_W-1:0]  hf_energy,
  output cod_pkg::stat_t                stat,
  output logic [cod_pkg::LEVEL_W-1:0]   onset_level
);
  import cod_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int RK_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int SUM_W = RK_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);
  localparam logic [RK_W-1:0]  MAX_RANK = RK_W'(WINDOW_LEN - 1);

  logic        [ENERGY_W-1:0] ewin [WINDOW_LEN];
  logic signed [CHANGE_W-1:0] cwin [WINDOW_LEN];
  logic        [IDX_W-1:0]    wpos;
  logic        [IDX_W-1:0]    idx;
  logic        [ENERGY_W-1:0] prev_energy;
  logic signed [PEAK_W-1:0]   prev_peak;
  logic        [RUN_W-1:0]    run;

  logic        [ENERGY_W-1:0] hf_q;
  logic signed [CHANGE_W-1:0] change_q;
  logic                       perc_hit_q;
  logic        [ENERGY_W-1:0] e_val;
  logic signed [CHANGE_W-1:0] c_val;
  logic        [LEVEL_W-1:0]  level_q;

  // Rank scan: the candidate at idx is compared with every entry at once.
  logic        [ENERGY_W-1:0]   e_cand;
  logic signed [CHANGE_W-1:0]   c_cand;
  logic        [WINDOW_LEN-1:0] e_lt, e_eq, c_lt, c_eq;
  logic        [SUM_W-1:0]      e_below, e_same, c_below, c_same;
  logic        [RK_W-1:0]       e_rank, c_rank;
  logic                         e_hit, c_hit;

  assign e_cand = ewin[idx];
  assign c_cand = cwin[idx];

  always_comb begin
    for (int j = 0; j < WINDOW_LEN; j++) begin
      e_lt[j] = ewin[j] < e_cand;
      e_eq[j] = ewin[j] == e_cand;
      c_lt[j] = cwin[j] < c_cand;
      c_eq[j] = cwin[j] == c_cand;
    end
  end

  assign e_rank  = (RK_W'(cfg.energy_rank) > MAX_RANK) ? MAX_RANK : RK_W'(cfg.energy_rank);
  assign c_rank  = (RK_W'(cfg.change_rank) > MAX_RANK) ? MAX_RANK : RK_W'(cfg.change_rank);
  assign e_below = SUM_W'($countones(e_lt));
  assign e_same  = SUM_W'($countones(e_eq));
  assign c_below = SUM_W'($countones(c_lt));
  assign c_same  = SUM_W'($countones(c_eq));
  assign e_hit   = (e_below <= {1'b0, e_rank}) && ({1'b0, e_rank} < e_below + e_same);
  assign c_hit   = (c_below <= {1'b0, c_rank}) && ({1'b0, c_rank} < c_below + c_same);

  // Decision on the picked window values.
  logic                     excess_pos;
  logic                     hard;
  logic                     falling;
  logic signed [PEAK_W-1:0] peak;

  always_comb begin
    excess_pos = hf_q > e_val;
    peak       = excess_pos ? signed'({change_q[CHANGE_W-1], change_q}
                                      - {c_val[CHANGE_W-1], c_val})
                            : '0;
    hard       = (cfg.mode != MODE_SOFT) && perc_hit_q && excess_pos;
    falling    = peak < prev_peak;
  end

  assign stat.mode_zero = (cfg.mode == MODE_PERC);
  assign stat.scan_last = (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ewin[i] <= '0;
        cwin[i] <= '0;
      end
      wpos        <= '0;
      idx         <= '0;
      prev_energy <= '0;
      prev_peak   <= '0;
      run         <= '0;
    end else begin
      if (cmd.write_win) begin
        ewin[wpos]  <= hf_q;
        cwin[wpos]  <= change_q;
        wpos        <= (wpos == LAST_IDX) ? '0 : wpos + 1'b1;
        prev_energy <= hf_q;
        idx         <= '0;
      end
      if (cmd.scan) begin
        idx <= stat.scan_last ? '0 : idx + 1'b1;
      end
      if (cmd.decide) begin
        prev_peak <= peak;
        priority if (hard) begin
          run <= '0;
        end else if (falling) begin
          run <= '0;
        end else if (run < RUN_MAX) begin
          run <= run + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      hf_q       <= hf_energy;
      change_q   <= signed'({1'b0, hf_energy} - {1'b0, prev_energy});
      perc_hit_q <= percussive_score > cfg.threshold;
      level_q    <= (percussive_score > cfg.threshold) ? LEVEL_HARD : LEVEL_NONE;
    end
    if (cmd.scan) begin
      // Every candidate that meets the rank test holds the same value.
      if (e_hit) begin
        e_val <= e_cand;
      end
      if (c_hit) begin
        c_val <= c_cand;
      end
    end
    if (cmd.decide) begin
      priority if (hard) begin
        level_q <= LEVEL_HARD;
      end else if (falling && run > RUN_MIN_SOFT && prev_peak > 0) begin
        level_q <= LEVEL_SOFT;
      end else begin
        level_q <= LEVEL_NONE;
      end
    end
    if (cmd.load_out) begin
      onset_level <= level_q;
    end
  end

  `ASSERT_ALWAYS(a_wpos_in_window, clk, rst, wpos <= LAST_IDX,
                 "window write position left the window")
  `ASSERT_NEXT(a_hard_clears_run, clk, rst, cmd.decide && hard, run == '0,
               "hard onset did not clear the rising run")

endmodule

[rtl/compound_onset_detector.sv]
// ----------------------------------------------------------------------------
// compound_onset_detector
// Per-frame onset level from a percussive score and high-frequency energy.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one request per analysis frame; the master stream
//   returns one onset level per request, in order. Registers are written on
//   the cfg port while no request is in work.
//   In compound and soft modes a request goes, after acceptance, through an
//   update of both windows, a rank scan over every window entry, a decision
//   and the load of the output register; the next request is taken only
//   after that load. The scan of the windows takes one candidate entry per
//   cycle. In percussive mode a request skips the window update, scan and
//   decision and goes from acceptance straight to the output register load.
//   Reset clears the windows, the previous energy and peak, the rising run
//   and the write position in the same cycle, and loads register defaults.
//   A stalled receiver holds the result in the output register; the next
//   request is still taken and worked on, and it waits for the register to
//   drain before it is loaded.
// ----------------------------------------------------------------------------
module compound_onset_detector #(
  parameter int WINDOW_LEN = 19
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // Fields from bit 0: percussive_score[16:0], hf_energy[48:17], zero pad.
  input  logic [cod_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // Fields from bit 0: onset_level[1:0], zero pad.
  output logic [cod_pkg::M_DATA_W-1:0]   m_tdata,
  input  logic                           cfg_we,
  input  logic [cod_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cod_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cod_pkg::*;

  cfg_t                cfg;
  cmd_t                cmd;
  stat_t               stat;
  logic [LEVEL_W-1:0]  onset_level;

  cod_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cod_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cod_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg              (cfg),
    .percussive_score (s_tdata[SCORE_W-1:0]),
    .hf_energy        (s_tdata[SCORE_W+ENERGY_W-1:SCORE_W]),
    .stat             (stat),
    .onset_level      (onset_level)
  );

  assign m_tdata = {{(M_DATA_W-LEVEL_W){1'b0}}, onset_level};

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the compound onset detector. Frames go in on the
// slave stream in random bursts while the master side stalls on a pattern of
// its own. A behavioral model of the windows, the peak measure and the
// rising-run counter predicts one onset level per accepted request, and each
// returned level is checked in order against it.
// ----------------------------------------------------------------------------
module tb_top;
  import cod_pkg::*;

  localparam int WIN = 19;
  localparam int PHASES = 14;
  localparam int PHASE_FRAMES = 125;

  localparam logic [SCORE_W-1:0]    SCORE_ONE  = 17'd65536;
  localparam logic [ENERGY_W-1:0]   ENERGY_MAX = 32'hFFFF_FFFF;
  localparam longint                ENERGY_TOP = 64'h0000_0000_FFFF_FFFF;
  localparam logic [MODE_W-1:0]     MODE_ALIAS = 2'd3;
  localparam logic [RANK_W-1:0]     RANK_TOP   = 5'd18;
  localparam logic [RANK_W-1:0]     RANK_OVER  = 5'd31;
  // Indexes with no register behind them; all three alias real ones in
  // their low bits.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 4'd13;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_C = 4'd15;

  typedef longint window_vals_t [WIN];

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Model state.
  logic [MODE_W-1:0]          mode_q;
  logic [SCORE_W-1:0]         thr_q;
  logic [RANK_W-1:0]          erank_q;
  logic [RANK_W-1:0]          crank_q;
  logic [ENERGY_W-1:0]        energy_hist [WIN];
  logic signed [CHANGE_W-1:0] change_hist [WIN];
  logic [ENERGY_W-1:0]        last_energy;
  logic signed [PEAK_W-1:0]   last_peak;
  logic [RUN_W-1:0]           run_len;
  int                         slot;

  logic [LEVEL_W-1:0] pending_levels [$];
  int                 level_errors;
  int                 frames_sent;
  int                 burst_left;

  compound_onset_detector #(.WINDOW_LEN(WIN)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Value at an ascending rank; ranks past the window end take the largest.
  function automatic longint window_pick(window_vals_t vals, logic [RANK_W-1:0] rank);
    int r;
    int below;
    int same;
    r = (rank > WIN - 1) ? WIN - 1 : int'(rank);
    for (int i = 0; i < WIN; i++) begin
      below = 0;
      same = 0;
      for (int j = 0; j < WIN; j++) begin
        if (vals[j] < vals[i]) below++;
        else if (vals[j] == vals[i]) same++;
      end
      if (below <= r && r < below + same) return vals[i];
    end
    return vals[0];
  endfunction

  function automatic logic [LEVEL_W-1:0] predict_onset(logic [SCORE_W-1:0] score,
                                                       logic [ENERGY_W-1:0] energy);
    logic               hit;
    longint             chg;
    longint             ewin;
    longint             cwin;
    longint             excess;
    longint             peak;
    longint             prev_pk;
    window_vals_t       vals;
    logic [LEVEL_W-1:0] level;
    hit = score > thr_q;
    if (mode_q == MODE_PERC) return hit ? LEVEL_HARD : LEVEL_NONE;
    chg = longint'({32'd0, energy}) - longint'({32'd0, last_energy});
    energy_hist[slot] = energy;
    change_hist[slot] = chg[CHANGE_W-1:0];
    slot = (slot == WIN - 1) ? 0 : slot + 1;
    for (int i = 0; i < WIN; i++) vals[i] = longint'({32'd0, energy_hist[i]});
    ewin = window_pick(vals, erank_q);
    for (int i = 0; i < WIN; i++) vals[i] = change_hist[i];
    cwin = window_pick(vals, crank_q);
    last_energy = energy;
    excess = longint'({32'd0, energy}) - ewin;
    peak = (excess > 0) ? chg - cwin : 0;
    prev_pk = last_peak;
    level = LEVEL_NONE;
    if (mode_q != MODE_SOFT && hit && excess > 0) begin
      level = LEVEL_HARD;
      run_len = '0;
    end else if (peak < prev_pk) begin
      if (run_len > RUN_MIN_SOFT && prev_pk > 0) level = LEVEL_SOFT;
      run_len = '0;
    end else if (run_len < RUN_MAX) begin
      run_len++;
    end
    last_peak = peak[PEAK_W-1:0];
    return level;
  endfunction

  // One request on the slave stream; the level is predicted on acceptance.
  // Valid stays high afterwards so that back-to-back requests need no drop.
  task automatic send_frame(logic [SCORE_W-1:0] score, logic [ENERGY_W-1:0] energy);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, energy, score};
    do @(posedge clk); while (!s_tready);
    pending_levels.push_back(predict_onset(score, energy));
    frames_sent++;
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= S_DATA_W'({$urandom(), $urandom()});
    end
  endtask

  // Stop sending and wait until every predicted level has come back.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_MODE:      mode_q  = value[MODE_W-1:0];
      REG_THRESHOLD: thr_q   = value[SCORE_W-1:0];
      REG_E_RANK:    erank_q = value[RANK_W-1:0];
      REG_C_RANK:    crank_q = value[RANK_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all four registers; with junk set, the bits above the narrow
  // fields carry random values that the block must drop.
  task automatic set_config(logic [MODE_W-1:0] mode, logic [SCORE_W-1:0] thr,
                            logic [RANK_W-1:0] erank, logic [RANK_W-1:0] crank,
                            bit junk);
    logic [CFG_DATA_W-1:0] wd;
    drain_results();
    wd = junk ? CFG_DATA_W'($urandom()) : '0;
    wd[MODE_W-1:0] = mode;
    cfg_write(REG_MODE, wd);
    cfg_write(REG_THRESHOLD, thr);
    wd = junk ? CFG_DATA_W'($urandom()) : '0;
    wd[RANK_W-1:0] = erank;
    cfg_write(REG_E_RANK, wd);
    wd = junk ? CFG_DATA_W'($urandom()) : '0;
    wd[RANK_W-1:0] = crank;
    cfg_write(REG_C_RANK, wd);
  endtask

  // Sender pacing: bursts of random length, random gaps, and now and then a
  // full drain before going on.
  task automatic paced_send(logic [SCORE_W-1:0] score, logic [ENERGY_W-1:0] energy);
    if (burst_left == 0) begin
      if ($urandom_range(0, 63) == 0) drain_results();
      else if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 30));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    send_frame(score, energy);
  endtask

  function automatic logic [SCORE_W-1:0] quiet_score();
    return ($urandom_range(0, 3) == 0) ? SCORE_W'($urandom_range(0, 65536))
                                       : SCORE_W'($urandom_range(0, 16000));
  endfunction

  function automatic logic [ENERGY_W-1:0] clamp_energy(longint e);
    return (e > ENERGY_TOP) ? ENERGY_MAX : (e < 0) ? '0 : e[ENERGY_W-1:0];
  endfunction

  // Energy rising with a growing step, then a smaller change so the peak
  // measure falls.
  task automatic send_rising_run();
    longint e;
    longint step;
    int     len;
    len  = $urandom_range(2, 20);
    e    = longint'($urandom() >> $urandom_range(0, 28));
    step = (e >> 5) + $urandom_range(1, 4096);
    for (int k = 0; k < len; k++) begin
      e = e + step;
      step = step + (step >> 3) + $urandom_range(0, 64);
      if (e > ENERGY_TOP) e = ENERGY_TOP;
      paced_send(quiet_score(), clamp_energy(e));
    end
    if ($urandom_range(0, 1) == 0) e = e - (e >> $urandom_range(1, 6));
    else e = e + (step >> $urandom_range(2, 8));
    paced_send(quiet_score(), clamp_energy(e));
  endtask

  // Quiet frames, a jump with a percussive score at or above the threshold, decay.
  task automatic send_hit();
    longint base;
    longint e;
    base = $urandom_range(0, 65535);
    repeat ($urandom_range(1, 6))
      paced_send(quiet_score(), clamp_energy(base + $urandom_range(0, 255)));
    e = base + longint'($urandom() >> $urandom_range(0, 16));
    paced_send(SCORE_W'($urandom_range(thr_q, 65536)), clamp_energy(e));
    repeat ($urandom_range(1, 3)) begin
      e = e - (e >> 2);
      paced_send(quiet_score(), clamp_energy(e));
    end
  endtask

  task automatic send_noise();
    logic [ENERGY_W-1:0] e;
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 7))
        0:       e = '0;
        1:       e = ENERGY_MAX;
        default: e = $urandom();
      endcase
      paced_send(SCORE_W'($urandom_range(0, 65536)), e);
    end
  endtask

  task automatic test_percussive_mode();
    set_config(MODE_PERC, THRESHOLD_RESET, E_RANK_RESET, C_RANK_RESET, 1'b0);
    send_frame('0, '0);
    send_frame(THRESHOLD_RESET, ENERGY_MAX);
    send_frame(THRESHOLD_RESET + 1'b1, 32'd1);
    send_frame(SCORE_ONE, '0);
    drain_results();
    // A score of one does not exceed a threshold of one.
    cfg_write(REG_THRESHOLD, SCORE_ONE);
    send_frame(SCORE_ONE, 32'h8000_0000);
    drain_results();
    cfg_write(REG_THRESHOLD, '0);
    send_frame('0, 32'h0000_FFFF);
    send_frame(17'd1, 32'hFFFF_0000);
  endtask

  // Writes to indexes with no register must leave the mode and threshold be.
  task automatic test_unused_registers();
    drain_results();
    cfg_write(REG_SPARE_A, CFG_DATA_W'(MODE_SOFT));
    cfg_write(REG_SPARE_B, SCORE_ONE);
    cfg_write(REG_SPARE_C, '1);
    send_frame(17'd1, 32'h1234_5678);
    send_frame('0, 32'h8765_4321);
  endtask

  task automatic test_hard_onset();
    set_config(MODE_COMPOUND, THRESHOLD_RESET, E_RANK_RESET, C_RANK_RESET, 1'b0);
    send_frame(SCORE_ONE, 32'h0001_0000);
    send_frame('0, ENERGY_MAX);
    send_frame(SCORE_ONE, '0);
    send_frame(THRESHOLD_RESET + 1'b1, 32'h8000_0000);
    // Mode three runs as compound; ranks past the window end pick the top.
    set_config(MODE_ALIAS, THRESHOLD_RESET, RANK_OVER, RANK_OVER, 1'b1);
    send_frame(SCORE_ONE, ENERGY_MAX);
    send_frame(17'd30000, 32'd7);
  endtask

  task automatic test_soft_onset();
    logic [ENERGY_W-1:0] ramp [10] = '{32'd1000, 32'd1100, 32'd1300, 32'd1700, 32'd2500,
                                       32'd4100, 32'd7300, 32'd13700, 32'd13800,
                                       32'd13800};
    // The score is ignored in soft mode, even far over a zero threshold.
    set_config(MODE_SOFT, '0, '0, '0, 1'b0);
    for (int k = 0; k < 10; k++) send_frame(SCORE_ONE, ramp[k]);
  endtask

  task automatic test_random_traffic();
    logic [MODE_W-1:0]  mode;
    logic [SCORE_W-1:0] thr;
    int                 phase_end;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_config(MODE_COMPOUND, '0, '0, '0, 1'b0);
        1: set_config(MODE_SOFT, SCORE_ONE, RANK_TOP, RANK_TOP, 1'b0);
        2: set_config(MODE_PERC, SCORE_ONE, RANK_OVER, RANK_OVER, 1'b1);
        3: set_config(MODE_COMPOUND, THRESHOLD_RESET, E_RANK_RESET, C_RANK_RESET, 1'b0);
        4: set_config(MODE_ALIAS, 17'd30000, RANK_TOP, '0, 1'b1);
        default: begin
          case ($urandom_range(0, 7))
            0:       mode = MODE_PERC;
            1:       mode = MODE_ALIAS;
            2, 3, 4: mode = MODE_SOFT;
            default: mode = MODE_COMPOUND;
          endcase
          thr = ($urandom_range(0, 3) == 0) ? SCORE_W'($urandom_range(0, 65536))
                                            : SCORE_W'($urandom_range(15000, 40000));
          set_config(mode, thr, RANK_W'($urandom_range(0, 31)),
                     RANK_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        end
      endcase
      burst_left = 0;
      phase_end = frames_sent + PHASE_FRAMES;
      while (frames_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send_rising_run();
          5, 6, 7:       send_hit();
          default:       send_noise();
        endcase
      end
    end
  endtask

  // Receiver stalls: ready runs and stall runs of random length, sometimes
  // long stretches with no stall at all.
  initial begin
    m_tready = 1'b0;
    forever begin
      repeat (($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24)) begin
        @(negedge clk);
        m_tready <= 1'b1;
      end
      repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12)) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logic [LEVEL_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_levels.size() == 0) begin
        $error("onset_level: no request waiting, actual %0d", m_tdata[LEVEL_W-1:0]);
        level_errors++;
      end else begin
        want = pending_levels.pop_front();
        if (m_tdata[LEVEL_W-1:0] !== want) begin
          $error("onset_level mismatch: expected %0d, actual %0d",
                 want, m_tdata[LEVEL_W-1:0]);
          level_errors++;
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    mode_q    = MODE_COMPOUND;
    thr_q     = THRESHOLD_RESET;
    erank_q   = E_RANK_RESET;
    crank_q   = C_RANK_RESET;
    for (int i = 0; i < WIN; i++) begin
      energy_hist[i] = '0;
      change_hist[i] = '0;
    end
    last_energy  = '0;
    last_peak    = '0;
    run_len      = '0;
    slot         = 0;
    level_errors = 0;
    frames_sent  = 0;
    burst_left   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_percussive_mode();
    test_unused_registers();
    test_hard_onset();
    test_soft_onset();
    test_random_traffic();

    drain_results();
    repeat (30) @(posedge clk);
    if (level_errors == 0 && pending_levels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
